// File: design/hdrx_pkg.sv
// ----------------------------------------------------------------------------
// hdrx_pkg
// Types and constants shared by the Ethernet/IP header extractor.
// ----------------------------------------------------------------------------
package hdrx_pkg;

    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
    localparam logic [3:0]  IHL_MASK       = 4'hF;
    localparam logic [6:0]  IPV4_MIN_HDR   = 7'd20;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  COUNT_MAX      = 8'd255;

    // frame byte offsets
    localparam logic [7:0]  OFS_SRC_MAC    = 8'd6;
    localparam logic [7:0]  OFS_ETYPE      = 8'd12;
    localparam logic [7:0]  OFS_L3         = 8'd14;
    localparam logic [7:0]  OFS_V4_IHL_END = 8'd15;
    localparam logic [7:0]  OFS_V4_PROTO   = 8'd23;
    localparam logic [7:0]  OFS_V4_SRC     = 8'd26;
    localparam logic [7:0]  OFS_V4_DST     = 8'd30;
    localparam logic [7:0]  OFS_V4_END     = 8'd34;
    localparam logic [7:0]  OFS_V6_NXT     = 8'd20;
    localparam logic [7:0]  OFS_V6_SRC     = 8'd22;
    localparam logic [7:0]  OFS_V6_SRC_LO  = 8'd30;
    localparam logic [7:0]  OFS_V6_DST     = 8'd38;
    localparam logic [7:0]  OFS_V6_DST_LO  = 8'd46;
    localparam logic [7:0]  OFS_V6_END     = 8'd54;

    typedef enum logic [1:0] {
        LK_OTHER  = 2'd0,
        LK_IPV4   = 2'd1,
        LK_V4_BAD = 2'd2,
        LK_IPV6   = 2'd3
    } layer_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } hdrx_in_t;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [7:0]  protocol;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        layer_kind_t layer_kind;
        logic        truncated;
    } hdrx_out_t;

    // input register status toward the parser and output stage
    typedef struct packed {
        logic     valid;
        logic     advance;
        hdrx_in_t item;
    } hdrx_stage_t;

    // per-frame capture state
    typedef struct packed {
        logic [7:0]  count;
        logic [5:0]  ihl_bytes;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] sport;
        logic [15:0] dport;
    } frame_state_t;

endpackage

// File: design/hdrx_in_stage.sv
// ----------------------------------------------------------------------------
// hdrx_in_stage
// Input register; holds a last byte while the output register is full and stalled.
// ----------------------------------------------------------------------------
module hdrx_in_stage
    import hdrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  hdrx_in_t    item,
    input  logic        out_free,
    output hdrx_stage_t stage
);

    logic     valid_reg;
    logic     valid_next;
    hdrx_in_t item_reg;
    logic     advance;
    logic     take;

    // non-last bytes always move on; a last byte needs room in the output
    assign advance    = valid_reg && (!item_reg.last_byte || out_free);
    assign item_stall = valid_reg && !advance;
    assign take       = item_valid && !item_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.advance = advance;
    assign stage.item    = item_reg;

endmodule

// File: design/hdrx_parse.sv
// ----------------------------------------------------------------------------
// hdrx_parse
// Per-frame capture state: offset decode and byte shift-in.
// ----------------------------------------------------------------------------
module hdrx_parse
    import hdrx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  hdrx_stage_t  stage,
    output frame_state_t cap
);

    frame_state_t state_reg;
    frame_state_t state_next;
    logic [7:0]   i;
    logic [7:0]   b;
    logic [7:0]   base;
    logic [7:0]   off;
    logic         port_ok;

    always_comb
    begin
        cap     = state_reg;
        i       = state_reg.count;
        b       = stage.item.data_byte;
        base    = OFS_L3 + {2'b00, state_reg.ihl_bytes};
        off     = i - base;
        port_ok = (i > OFS_L3) && ({1'b0, state_reg.ihl_bytes} >= IPV4_MIN_HDR)
                  && ((state_reg.proto == PROTO_TCP) || (state_reg.proto == PROTO_UDP))
                  && (i >= base);

        if (i < OFS_SRC_MAC)
        begin
            cap.dst_mac = {state_reg.dst_mac[39:0], b};
        end
        else if (i < OFS_ETYPE)
        begin
            cap.src_mac = {state_reg.src_mac[39:0], b};
        end
        else if (i < OFS_L3)
        begin
            cap.etype = {state_reg.etype[7:0], b};
        end
        else if (state_reg.etype == ETYPE_IPV4)
        begin
            if (i == OFS_L3)
            begin
                cap.ihl_bytes = {b[3:0] & IHL_MASK, 2'b00};
            end
            else if (i == OFS_V4_PROTO)
            begin
                cap.proto = b;
            end
            else if (i >= OFS_V4_SRC && i < OFS_V4_DST)
            begin
                cap.src_lo = {32'd0, state_reg.src_lo[23:0], b};
            end
            else if (i >= OFS_V4_DST && i < OFS_V4_END)
            begin
                cap.dst_lo = {32'd0, state_reg.dst_lo[23:0], b};
            end
            if (port_ok)
            begin
                if (off < 8'd2)
                begin
                    cap.sport = {state_reg.sport[7:0], b};
                end
                else if (off < 8'd4)
                begin
                    cap.dport = {state_reg.dport[7:0], b};
                end
            end
        end
        else if (state_reg.etype == ETYPE_IPV6)
        begin
            if (i == OFS_V6_NXT)
            begin
                cap.proto = b;
            end
            else if (i >= OFS_V6_SRC && i < OFS_V6_SRC_LO)
            begin
                cap.src_hi = {state_reg.src_hi[55:0], b};
            end
            else if (i >= OFS_V6_SRC_LO && i < OFS_V6_DST)
            begin
                cap.src_lo = {state_reg.src_lo[55:0], b};
            end
            else if (i >= OFS_V6_DST && i < OFS_V6_DST_LO)
            begin
                cap.dst_hi = {state_reg.dst_hi[55:0], b};
            end
            else if (i >= OFS_V6_DST_LO && i < OFS_V6_END)
            begin
                cap.dst_lo = {state_reg.dst_lo[55:0], b};
            end
        end

        cap.count = (i == COUNT_MAX) ? COUNT_MAX : i + 8'd1;

        // frame state clears after the last byte
        if (stage.advance)
        begin
            state_next = stage.item.last_byte ? '0 : cap;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/hdrx_out_stage.sv
// ----------------------------------------------------------------------------
// hdrx_out_stage
// Result assembly with reach checks, and the result register.
// ----------------------------------------------------------------------------
module hdrx_out_stage
    import hdrx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  hdrx_stage_t  stage,
    input  frame_state_t cap,
    output logic         out_free,
    output logic         result_valid,
    input  logic         result_stall,
    output hdrx_out_t    result
);

    hdrx_out_t res;
    hdrx_out_t result_reg;
    logic      valid_reg;
    logic      valid_next;
    logic      load;
    logic [7:0] n;
    logic [8:0] port_base;

    always_comb
    begin
        res       = '0;
        n         = cap.count;
        port_base = {1'b0, OFS_L3} + {3'd0, cap.ihl_bytes};

        if (n >= OFS_SRC_MAC)
        begin
            res.dst_mac = cap.dst_mac;
        end
        if (n >= OFS_ETYPE)
        begin
            res.src_mac = cap.src_mac;
        end
        if (n < OFS_L3)
        begin
            res.truncated = 1'b1;
        end
        else
        begin
            res.ethertype = cap.etype;
            if (cap.etype == ETYPE_IPV4)
            begin
                res.layer_kind = LK_IPV4;
                if (n < OFS_V4_IHL_END)
                begin
                    res.truncated = 1'b1;
                end
                else if ({1'b0, cap.ihl_bytes} < IPV4_MIN_HDR)
                begin
                    res.layer_kind = LK_V4_BAD;
                end
                else
                begin
                    if (n > OFS_V4_PROTO) res.protocol = cap.proto;
                    else res.truncated = 1'b1;
                    if (n >= OFS_V4_DST) res.src_addr_low = cap.src_lo;
                    else res.truncated = 1'b1;
                    if (n >= OFS_V4_END) res.dst_addr_low = cap.dst_lo;
                    else res.truncated = 1'b1;
                    if ((n > OFS_V4_PROTO)
                        && ((cap.proto == PROTO_TCP) || (cap.proto == PROTO_UDP)))
                    begin
                        if ({1'b0, n} >= port_base + 9'd2) res.source_port = cap.sport;
                        else res.truncated = 1'b1;
                        if ({1'b0, n} >= port_base + 9'd4) res.dest_port = cap.dport;
                        else res.truncated = 1'b1;
                    end
                end
            end
            else if (cap.etype == ETYPE_IPV6)
            begin
                res.layer_kind = LK_IPV6;
                if (n > OFS_V6_NXT) res.protocol = cap.proto;
                else res.truncated = 1'b1;
                if (n >= OFS_V6_DST)
                begin
                    res.src_addr_high = cap.src_hi;
                    res.src_addr_low  = cap.src_lo;
                end
                else
                begin
                    res.truncated = 1'b1;
                end
                if (n >= OFS_V6_END)
                begin
                    res.dst_addr_high = cap.dst_hi;
                    res.dst_addr_low  = cap.dst_lo;
                end
                else
                begin
                    res.truncated = 1'b1;
                end
            end
        end
    end

    assign out_free   = !valid_reg || !result_stall;
    assign load       = stage.advance && stage.item.last_byte;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// File: design/ethernet_ip_header_extractor_top.sv
// ----------------------------------------------------------------------------
// ethernet_ip_header_extractor_top
// Byte-wide Ethernet/IPv4/IPv6 header parser giving one result per frame.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | payload    | transaction
//  --------+----------------------------------+------------+--------------------
//  item    | item_valid, item_stall, item     | hdrx_in_t  | one frame byte
//  result  | result_valid, result_stall, result| hdrx_out_t | one parsed frame
//
//  Cycles: a byte enters every cycle while item_stall is low; the result of a frame
//  is valid once its last byte has passed the input register, then the result register.
//  Reset: rst_n clears the valid flags and the frame capture state; payload
//  registers are not reset.
//  Stalls: only a last byte can wait in the input register, and only while the
//  result register is full and stalled; item_stall then rises.
//
module ethernet_ip_header_extractor_top
    import hdrx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  hdrx_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output hdrx_out_t result
);

    hdrx_stage_t  stage;
    frame_state_t cap;
    logic         out_free;

    // input register
    hdrx_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .out_free   (out_free),
        .stage      (stage)
    );

    // offset decode and capture of header bytes
    hdrx_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .cap   (cap)
    );

    // field selection on the last byte, result register
    hdrx_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .cap          (cap),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // a byte that is not last never waits
    a_nonlast_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && !stage.item.last_byte) |-> stage.advance)
        else $error("non-last byte held in input register");

    // upstream stall only when a last byte is blocked by a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage.valid && stage.item.last_byte && result_valid && result_stall))
        else $error("item_stall without a blocked last byte");

    // a last byte that moves on produces a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.advance && stage.item.last_byte) |=> result_valid)
        else $error("last byte did not produce a result");

    // ports appear only for IPv4 with a good header
    a_ports_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.layer_kind != LK_IPV4)
            |-> (result.source_port == 16'd0 && result.dest_port == 16'd0))
        else $error("ports set outside IPv4");
`endif

endmodule
